// File: rtl/bmcs_pkg.sv
// ----------------------------------------------------------------------------
// bmcs_pkg: shared types and constants of the clip sequencer
// Request and response payloads, event codes, action codes and the command
// and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package bmcs_pkg;

    localparam int NUM_CLIPS_DEF = 8;

    localparam int KIND_W   = 3;
    localparam int IDX_W    = 3;
    localparam int ENTRY_W  = 16;
    localparam int DRAW_W   = 15;
    localparam int WEIGHT_W = 9;
    localparam int ACTION_W = 2;

    // one blended element: entry times a weight of at most 256
    localparam int BLEND_W  = ENTRY_W + 8;

    localparam logic [WEIGHT_W-1:0] FULL_WEIGHT = 9'd256;

    localparam logic [KIND_W-1:0] KIND_WR_NORMAL  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_WR_INTENSE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PLAY       = 3'd2;
    localparam logic [KIND_W-1:0] KIND_IDLE       = 3'd3;
    localparam logic [KIND_W-1:0] KIND_STOP       = 3'd4;
    localparam logic [KIND_W-1:0] KIND_FINISHED   = 3'd5;

    localparam logic [ACTION_W-1:0] ACT_NONE     = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_START    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_STOP     = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_STOP_ALL = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [IDX_W-1:0]   row;
        logic [IDX_W-1:0]   column;
        logic [ENTRY_W-1:0] probability;
        logic [DRAW_W-1:0]  random_value;
    } t_req;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [IDX_W-1:0]    clip_index;
    } t_rsp;

    typedef struct packed {
        logic wr_normal;   // write normal entry from the request
        logic wr_intense;  // write intense entry from the request
        logic scan_clr;    // clear accumulator and found flag, latch the draw
        logic cur_clr;     // reset current clip to zero
        logic rd_en;       // issue one row element read
        logic cur_load;    // commit the scan result to the current clip
    } t_dp_cmd;

    typedef struct packed {
        logic [IDX_W-1:0] cur_clip;
        logic [IDX_W-1:0] next_clip;
    } t_dp_stat;

endpackage

// File: rtl/bmcs_datapath.sv
// ----------------------------------------------------------------------------
// bmcs_datapath: transition tables, blend pipeline and row accumulator
// Holds both tables as memories, the intensity register and the current
// clip; scans one row element per issued read.
// ----------------------------------------------------------------------------
module bmcs_datapath #(
    parameter int NUM_CLIPS = bmcs_pkg::NUM_CLIPS_DEF,
    parameter int CW        = (NUM_CLIPS > 1) ? $clog2(NUM_CLIPS) : 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  bmcs_pkg::t_dp_cmd               i_cmd,
    input  logic [CW-1:0]                   i_rd_col,
    input  bmcs_pkg::t_req                  i_req,
    input  logic                            i_cfg_we,
    input  logic [bmcs_pkg::WEIGHT_W-1:0]   i_cfg_wdata,
    output bmcs_pkg::t_dp_stat              o_stat
);

    localparam int DEPTH = NUM_CLIPS * NUM_CLIPS;
    localparam int AW    = $clog2(DEPTH);
    localparam int ACC_W = bmcs_pkg::BLEND_W + CW;
    localparam int PROD_W = bmcs_pkg::ENTRY_W + bmcs_pkg::WEIGHT_W;

    logic [bmcs_pkg::ENTRY_W-1:0] r_mem_n [DEPTH];
    logic [bmcs_pkg::ENTRY_W-1:0] r_mem_i [DEPTH];

    logic [bmcs_pkg::WEIGHT_W-1:0] r_intensity;
    logic [bmcs_pkg::DRAW_W-1:0]   r_draw;
    logic [CW-1:0]                 r_cur;

    logic                          r_v1, r_v2;
    logic [CW-1:0]                 r_c1, r_c2;
    logic [bmcs_pkg::ENTRY_W-1:0]  r_pn, r_pi;
    logic [bmcs_pkg::BLEND_W-1:0]  r_blend;
    logic [ACC_W-1:0]              r_acc;
    logic                          r_found;
    logic [CW-1:0]                 r_hit;

    logic                          wr_ok;
    logic [AW-1:0]                 waddr, raddr;
    logic [bmcs_pkg::WEIGHT_W-1:0] w_int, w_nrm;
    logic [PROD_W-1:0]             prod_n, prod_i, prod_sum;
    logic [ACC_W-1:0]              n_acc, target;

    assign wr_ok = (int'(i_req.row) < NUM_CLIPS) && (int'(i_req.column) < NUM_CLIPS);
    assign waddr = AW'(int'(i_req.row) * NUM_CLIPS + int'(i_req.column));
    assign raddr = AW'(int'(r_cur) * NUM_CLIPS + int'(i_rd_col));

    // tables: one write port from requests, one read port for the scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_normal && wr_ok) begin
            r_mem_n[waddr] <= i_req.probability;
        end
        if (i_cmd.wr_intense && wr_ok) begin
            r_mem_i[waddr] <= i_req.probability;
        end
        if (i_cmd.rd_en) begin
            r_pn <= r_mem_n[raddr];
            r_pi <= r_mem_i[raddr];
        end
    end

    // saturate the weight at fully intense
    assign w_int = (r_intensity > bmcs_pkg::FULL_WEIGHT) ? bmcs_pkg::FULL_WEIGHT : r_intensity;
    assign w_nrm = bmcs_pkg::FULL_WEIGHT - w_int;

    assign prod_n   = PROD_W'(r_pn) * PROD_W'(w_nrm);
    assign prod_i   = PROD_W'(r_pi) * PROD_W'(w_int);
    assign prod_sum = prod_n + prod_i;

    assign n_acc  = r_acc + ACC_W'(r_blend);
    assign target = ACC_W'({r_draw, 8'h00});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_intensity <= '0;
            r_cur       <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_found     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_intensity <= i_cfg_wdata;
            end
            r_v1 <= i_cmd.rd_en;
            r_v2 <= r_v1;
            if (i_cmd.scan_clr) begin
                r_found <= 1'b0;
            end else if (r_v2 && !r_found && (n_acc >= target)) begin
                r_found <= 1'b1;
            end
            if (i_cmd.cur_clr) begin
                r_cur <= '0;
            end else if (i_cmd.cur_load && r_found) begin
                r_cur <= r_hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_clr) begin
            r_draw <= i_req.random_value;
            r_acc  <= '0;
        end else if (r_v2 && !r_found) begin
            r_acc <= n_acc;
            r_hit <= r_c2;
        end
        r_c1    <= i_rd_col;
        r_c2    <= r_c1;
        // weights add to full scale, so the blend fits BLEND_W bits
        r_blend <= prod_sum[bmcs_pkg::BLEND_W-1:0];
    end

    assign o_stat.cur_clip  = bmcs_pkg::IDX_W'(r_cur);
    assign o_stat.next_clip = r_found ? bmcs_pkg::IDX_W'(r_hit) : bmcs_pkg::IDX_W'(r_cur);

endmodule

// File: rtl/bmcs_ctrl.sv
// ----------------------------------------------------------------------------
// bmcs_ctrl: event decoder and scan sequencer
// Keeps the idle and playing flags, decodes each request into an action and
// steps the datapath through a row scan where a next clip is chosen.
// ----------------------------------------------------------------------------
module bmcs_ctrl #(
    parameter int NUM_CLIPS = bmcs_pkg::NUM_CLIPS_DEF,
    parameter int CW        = (NUM_CLIPS > 1) ? $clog2(NUM_CLIPS) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  bmcs_pkg::t_req      i_req,
    input  bmcs_pkg::t_dp_stat  i_stat,
    output logic                o_busy,
    output bmcs_pkg::t_dp_cmd   o_cmd,
    output logic [CW-1:0]       o_rd_col,
    output logic                o_valid,
    output bmcs_pkg::t_rsp      o_rsp
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DRAIN  = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]      r_state, n_state;
    logic [CW-1:0]   r_col, n_col;
    logic            r_drain, n_drain;
    logic            r_idle, n_idle;
    logic            r_playing, n_playing;
    logic            r_valid, n_valid;
    bmcs_pkg::t_rsp  r_rsp, n_rsp;
    logic            accept;
    logic            scan_go;

    assign accept = i_start && (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_col     = r_col;
        n_drain   = r_drain;
        n_idle    = r_idle;
        n_playing = r_playing;
        n_valid   = 1'b0;
        n_rsp     = '{action: bmcs_pkg::ACT_NONE, clip_index: '0};
        o_cmd     = '0;
        scan_go   = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_valid = 1'b1;
                    case (i_req.kind)
                        bmcs_pkg::KIND_WR_NORMAL: begin
                            o_cmd.wr_normal = 1'b1;
                        end
                        bmcs_pkg::KIND_WR_INTENSE: begin
                            o_cmd.wr_intense = 1'b1;
                        end
                        bmcs_pkg::KIND_PLAY: begin
                            if (r_idle && r_playing) begin
                                n_idle       = 1'b0;
                                n_rsp.action = bmcs_pkg::ACT_STOP;
                            end else if (r_playing) begin
                                n_rsp.action     = bmcs_pkg::ACT_STOP;
                                n_rsp.clip_index = i_stat.cur_clip;
                            end else begin
                                n_idle        = 1'b0;
                                n_playing     = 1'b1;
                                o_cmd.cur_clr = 1'b1;
                                scan_go       = 1'b1;
                            end
                        end
                        bmcs_pkg::KIND_IDLE: begin
                            if (!r_idle && r_playing) begin
                                n_idle           = 1'b1;
                                n_rsp.action     = bmcs_pkg::ACT_STOP;
                                n_rsp.clip_index = i_stat.cur_clip;
                            end else if (!r_playing) begin
                                n_idle       = 1'b1;
                                n_playing    = 1'b1;
                                n_rsp.action = bmcs_pkg::ACT_START;
                            end
                        end
                        bmcs_pkg::KIND_STOP: begin
                            n_playing    = 1'b0;
                            n_rsp.action = bmcs_pkg::ACT_STOP_ALL;
                        end
                        bmcs_pkg::KIND_FINISHED: begin
                            if (r_idle && r_playing) begin
                                n_rsp.action = bmcs_pkg::ACT_START;
                            end else if (r_playing) begin
                                scan_go = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (scan_go) begin
                        // hold the result until the scan finishes
                        n_valid        = 1'b0;
                        o_cmd.scan_clr = 1'b1;
                        n_col          = '0;
                        n_state        = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.rd_en = 1'b1;
                if (r_col == CW'(NUM_CLIPS - 1)) begin
                    n_drain = 1'b0;
                    n_state = S_DRAIN;
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
            S_DRAIN: begin
                // wait for the last element to reach the accumulator
                n_drain = 1'b1;
                if (r_drain) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                o_cmd.cur_load   = 1'b1;
                n_valid          = 1'b1;
                n_rsp.action     = bmcs_pkg::ACT_START;
                n_rsp.clip_index = i_stat.next_clip;
                n_state          = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_col     <= '0;
            r_drain   <= 1'b0;
            r_idle    <= 1'b0;
            r_playing <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_col     <= n_col;
            r_drain   <= n_drain;
            r_idle    <= n_idle;
            r_playing <= n_playing;
            r_valid   <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_rd_col = r_col;
    assign o_valid  = r_valid;
    assign o_rsp    = r_rsp;

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (int'(r_col) < NUM_CLIPS))
        else $error("scan column beyond row");

    a_rsp_in_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_state == S_IDLE))
        else $error("response strobe outside idle state");

    a_scan_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && scan_go) |=> ((r_state == S_SCAN) && (r_col == '0) && !r_valid))
        else $error("scan request did not enter scan");

    a_finish_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH) |=> (r_valid && (r_rsp.action == bmcs_pkg::ACT_START)))
        else $error("scan end without start response");

    a_finish_playing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH) |-> (r_playing && !r_idle))
        else $error("scan finished while not playing");

endmodule

// File: rtl/blended_markov_clip_sequencer.sv
// ----------------------------------------------------------------------------
// blended_markov_clip_sequencer: Markov-chain clip sequencer
// Two transition tables blended by an intensity weight pick the next clip
// by an inverse cumulative scan of the current row.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive i_req and raise start; the request is taken at a
//   clock edge where start is high and busy is low. Table writes and the
//   play, idle, stop and clip-finished events all travel on this channel.
//   Response channel: every request yields exactly one response, shown on
//   o_rsp for a single cycle while o_valid is high. The receiver cannot
//   stall it, so capture it in that cycle.
//   Configuration: i_cfg_we with i_cfg_wdata loads the intensity weight
//   (256 = fully intense, larger values saturate). Write it only while idle.
//   Request handling: a request that needs no next-clip choice answers in the
//   cycle after it is taken, and busy stays low, so one such request a cycle
//   is taken. A request that chooses a clip (play from stopped, clip finished
//   while playing and not idle) scans the row one element a cycle through the
//   table read port and a two-stage blend and accumulate pipeline, with busy
//   high from accept to response.
//   Reset: flags, current clip and intensity clear; table contents are kept
//   and must be written before use. No clearing pass is run.
// ----------------------------------------------------------------------------
module blended_markov_clip_sequencer #(
    parameter int NUM_CLIPS = bmcs_pkg::NUM_CLIPS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  bmcs_pkg::t_req                  i_req,
    output logic                            o_valid,
    output bmcs_pkg::t_rsp                  o_rsp,
    input  logic                            i_cfg_we,
    input  logic [bmcs_pkg::WEIGHT_W-1:0]   i_cfg_wdata
);

    // clip index width inside the block
    localparam int CW = (NUM_CLIPS > 1) ? $clog2(NUM_CLIPS) : 1;

    bmcs_pkg::t_dp_cmd  dp_cmd;
    bmcs_pkg::t_dp_stat dp_stat;
    logic [CW-1:0]      rd_col;

    // controller: decode events, advance the scan, register the response
    bmcs_ctrl #(
        .NUM_CLIPS (NUM_CLIPS),
        .CW        (CW)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_req    (i_req),
        .i_stat   (dp_stat),
        .o_busy   (busy),
        .o_cmd    (dp_cmd),
        .o_rd_col (rd_col),
        .o_valid  (o_valid),
        .o_rsp    (o_rsp)
    );

    // datapath: tables, blend, accumulate against the draw, current clip
    bmcs_datapath #(
        .NUM_CLIPS (NUM_CLIPS),
        .CW        (CW)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .i_rd_col    (rd_col),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_stat      (dp_stat)
    );

endmodule
